### src/vln_pkg.sv
// ----------------------------------------------------------------------------
// vln_pkg
// Shared constants, types and helpers of the L2 vector normaliser.
// ----------------------------------------------------------------------------
package vln_pkg;

  localparam int unsigned MAX_LENGTH  = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_LENGTH);
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned SQ_W        = 31;
  localparam int unsigned SUM_W       = 38;
  localparam int unsigned QUO_W       = 32;
  localparam int unsigned ROOT_W      = QUO_W / 2;
  localparam int unsigned SREM_W      = ROOT_W + 2;
  localparam int unsigned STEP_W      = $clog2(QUO_W);
  localparam int unsigned MAG_W       = DATA_W - 1;
  localparam int unsigned ADDR_W      = IDX_W + 1;
  localparam int unsigned QCNT_W      = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LENGTH);
  localparam logic [MAG_W-1:0] MAG_SAT   = '1;

  // one completed vector waiting for the back end
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [SUM_W-1:0] sum;
  } desc_t;

  // element store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_PREP,
    ST_DIV,
    ST_SQRT,
    ST_EMIT
  } back_state_e;

  // zero acts as one, anything above MAX_LENGTH as MAX_LENGTH
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] cfg);
    logic [LEN_W-1:0] len;
    if (cfg == '0) begin
      len = LEN_W'(1);
    end else if (cfg > LEN_W'(MAX_LENGTH)) begin
      len = LEN_W'(MAX_LENGTH);
    end else begin
      len = cfg;
    end
    return len;
  endfunction

endpackage

### src/vln_front.sv
// ----------------------------------------------------------------------------
// vln_front
// Accepts elements, writes them to the store and accumulates the sum of
// squares; hands each completed vector to the descriptor queue.
// ----------------------------------------------------------------------------
module vln_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vln_pkg::LEN_W-1:0]          vector_length_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [vln_pkg::DATA_W-1:0]  element_value_i,
  input  logic [vln_pkg::QCNT_W-1:0]         q_count_i,
  output logic                               push_o,
  output vln_pkg::desc_t                     push_desc_o,
  output vln_pkg::mem_wr_t                   mem_wr_o
);

  logic [vln_pkg::LEN_W-1:0]  cfg_q;
  logic [vln_pkg::LEN_W-1:0]  len;
  logic [vln_pkg::IDX_W-1:0]  count_q, count_d;
  logic                       bank_q, bank_d;
  logic                       sq_valid_q;
  logic                       sq_last_q;
  logic                       sq_bank_q;
  logic [vln_pkg::LEN_W-1:0]  sq_len_q;
  logic [vln_pkg::SQ_W-1:0]   sq_q;
  logic [vln_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [vln_pkg::SUM_W-1:0]  sum_next;
  logic signed [2*vln_pkg::DATA_W-1:0] square;
  logic                       accept;
  logic                       is_last;

  assign len     = vln_pkg::eff_length(cfg_q);
  // both banks may be spoken for once a pending vector lands in the queue
  assign in_stall_o = (q_count_i == vln_pkg::QCNT_W'(vln_pkg::QUEUE_DEPTH)) ||
                      ((q_count_i == vln_pkg::QCNT_W'(1)) && sq_valid_q && sq_last_q);
  assign accept  = in_valid_i && !in_stall_o;
  assign is_last = ({1'b0, count_q} + vln_pkg::LEN_W'(1)) == len;
  assign square  = element_value_i * element_value_i;
  assign sum_next = sum_q + vln_pkg::SUM_W'(sq_q);

  assign mem_wr_o.en   = accept;
  assign mem_wr_o.addr = {bank_q, count_q};
  assign mem_wr_o.data = element_value_i;

  assign push_o           = sq_valid_q && sq_last_q;
  assign push_desc_o.bank = sq_bank_q;
  assign push_desc_o.len  = sq_len_q;
  assign push_desc_o.sum  = sum_next;

  always_comb begin
    count_d = count_q;
    bank_d  = bank_q;
    if (accept) begin
      if (is_last) begin
        count_d = '0;
        bank_d  = ~bank_q;
      end else begin
        count_d = count_q + vln_pkg::IDX_W'(1);
      end
    end
    if (cfg_we_i) begin
      count_d = '0;
    end
  end

  always_comb begin
    sum_d = sum_q;
    if (sq_valid_q) begin
      sum_d = sq_last_q ? '0 : sum_next;
    end
    if (cfg_we_i) begin
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= vln_pkg::LEN_RESET;
      count_q    <= '0;
      bank_q     <= 1'b0;
      sum_q      <= '0;
      sq_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= vector_length_i;
      end
      count_q    <= count_d;
      bank_q     <= bank_d;
      sum_q      <= sum_d;
      sq_valid_q <= accept && !cfg_we_i;
    end
  end

  // square stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q      <= square[vln_pkg::SQ_W-1:0];
      sq_last_q <= is_last;
      sq_bank_q <= bank_q;
      sq_len_q  <= len;
    end
  end

endmodule

### src/vln_queue.sv
// ----------------------------------------------------------------------------
// vln_queue
// Two-entry descriptor queue between the front and the back end.
// ----------------------------------------------------------------------------
module vln_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  vln_pkg::desc_t             push_desc_i,
  input  logic                       pop_i,
  output logic                       head_valid_o,
  output vln_pkg::desc_t             head_o,
  output logic [vln_pkg::QCNT_W-1:0] count_o
);

  vln_pkg::desc_t                 entries_q [vln_pkg::QUEUE_DEPTH];
  logic                           wr_ptr_q;
  logic                           rd_ptr_q;
  logic [vln_pkg::QCNT_W-1:0]     count_q;

  assign head_valid_o = count_q != '0;
  assign head_o       = entries_q[rd_ptr_q];
  assign count_o      = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + vln_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - vln_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

### src/vln_back.sv
// ----------------------------------------------------------------------------
// vln_back
// Element store and normalising sequencer: per element a restoring divide of
// x^2 * 2^32 by the sum of squares, an integer square root, then rounding.
// ----------------------------------------------------------------------------
module vln_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  vln_pkg::mem_wr_t                   mem_wr_i,
  input  logic                               head_valid_i,
  input  vln_pkg::desc_t                     head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vln_pkg::DATA_W-1:0]  normalized_value_o,
  output logic                               last_element_o
);

  logic [vln_pkg::DATA_W-1:0]   store_q [2*vln_pkg::MAX_LENGTH];
  logic [vln_pkg::DATA_W-1:0]   rdata_q;

  vln_pkg::back_state_e         state_q, state_d;
  logic [vln_pkg::IDX_W-1:0]    k_q;
  logic [vln_pkg::STEP_W-1:0]   step_q;
  logic                         neg_q;
  logic [vln_pkg::SQ_W-1:0]     mag_sq_q;
  logic [vln_pkg::SUM_W-1:0]    rem_q;
  logic [vln_pkg::QUO_W-1:0]    quo_q;
  logic [vln_pkg::ROOT_W-1:0]   root_q;
  logic [vln_pkg::SREM_W-1:0]   srem_q;
  logic [vln_pkg::MAG_W-1:0]    res_q;

  logic                         out_valid_q;
  logic [vln_pkg::DATA_W-1:0]   out_value_q;
  logic                         out_last_q;

  logic                         is_last;
  logic                         slot_free;
  logic                         out_load;
  logic [vln_pkg::DATA_W-1:0]   mag;
  logic [2*vln_pkg::DATA_W-1:0] mag_sq;
  logic [vln_pkg::SUM_W:0]      rem2;
  logic                         div_ge;
  logic [vln_pkg::SUM_W:0]      div_sub;
  logic [vln_pkg::SREM_W:0]     srem2;
  logic [vln_pkg::SREM_W:0]     trial;
  logic                         sq_ge;
  logic [vln_pkg::SREM_W:0]     sq_sub;
  logic [vln_pkg::ROOT_W-1:0]   root_d;
  logic [vln_pkg::ROOT_W:0]     rounded;
  logic [vln_pkg::DATA_W-1:0]   signed_res;

  // element store: written by the front, read one element at a time here
  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      store_q[mem_wr_i.addr] <= mem_wr_i.data;
    end
    if (state_q == vln_pkg::ST_READ) begin
      rdata_q <= store_q[{head_i.bank, k_q}];
    end
  end

  assign is_last   = ({1'b0, k_q} + vln_pkg::LEN_W'(1)) == head_i.len;
  assign slot_free = !out_valid_q || !out_stall_i;

  assign mag    = rdata_q[vln_pkg::DATA_W-1] ? (~rdata_q + vln_pkg::DATA_W'(1)) : rdata_q;
  assign mag_sq = mag * mag;

  // one quotient bit per cycle; the remainder always stays below the sum
  assign rem2    = {rem_q, 1'b0};
  assign div_ge  = rem2 >= {1'b0, head_i.sum};
  assign div_sub = rem2 - {1'b0, head_i.sum};

  // one root bit per cycle, radicand consumed two bits at a time from the top
  assign srem2  = {srem_q[vln_pkg::ROOT_W:0], quo_q[vln_pkg::QUO_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign sq_ge  = srem2 >= trial;
  assign sq_sub = srem2 - trial;
  assign root_d = {root_q[vln_pkg::ROOT_W-2:0], sq_ge};

  // largest n with 2n-1 <= root, saturated to full scale
  assign rounded = {1'b0, root_d} + (vln_pkg::ROOT_W+1)'(1);

  assign signed_res = neg_q ? (~{1'b0, res_q} + vln_pkg::DATA_W'(1)) : {1'b0, res_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vln_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          state_d = vln_pkg::ST_READ;
        end
      end
      vln_pkg::ST_READ:   state_d = vln_pkg::ST_SQUARE;
      vln_pkg::ST_SQUARE: state_d = vln_pkg::ST_PREP;
      vln_pkg::ST_PREP: begin
        if ((head_i.sum == '0) || (vln_pkg::SUM_W'(mag_sq_q) >= head_i.sum)) begin
          state_d = vln_pkg::ST_EMIT;
        end else begin
          state_d = vln_pkg::ST_DIV;
        end
      end
      vln_pkg::ST_DIV: begin
        if (step_q == '0) begin
          state_d = vln_pkg::ST_SQRT;
        end
      end
      vln_pkg::ST_SQRT: begin
        if (step_q == '0) begin
          state_d = vln_pkg::ST_EMIT;
        end
      end
      vln_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = is_last ? vln_pkg::ST_IDLE : vln_pkg::ST_READ;
        end
      end
      default: state_d = vln_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    out_load = 1'b0;
    pop_o    = 1'b0;
    case (state_q)
      vln_pkg::ST_EMIT: begin
        out_load = slot_free;
        pop_o    = slot_free && is_last;
      end
      default: begin
        out_load = 1'b0;
        pop_o    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vln_pkg::ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        k_q <= '0;
      end else if (out_load) begin
        k_q <= k_q + vln_pkg::IDX_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      vln_pkg::ST_SQUARE: begin
        neg_q    <= rdata_q[vln_pkg::DATA_W-1];
        mag_sq_q <= mag_sq[vln_pkg::SQ_W-1:0];
      end
      vln_pkg::ST_PREP: begin
        rem_q  <= vln_pkg::SUM_W'(mag_sq_q);
        quo_q  <= '0;
        step_q <= vln_pkg::STEP_W'(vln_pkg::QUO_W - 1);
        if (head_i.sum == '0) begin
          res_q <= '0;
        end else begin
          res_q <= vln_pkg::MAG_SAT;
        end
      end
      vln_pkg::ST_DIV: begin
        rem_q  <= div_ge ? div_sub[vln_pkg::SUM_W-1:0] : rem2[vln_pkg::SUM_W-1:0];
        quo_q  <= {quo_q[vln_pkg::QUO_W-2:0], div_ge};
        root_q <= '0;
        srem_q <= '0;
        if (step_q == '0) begin
          step_q <= vln_pkg::STEP_W'(vln_pkg::ROOT_W - 1);
        end else begin
          step_q <= step_q - vln_pkg::STEP_W'(1);
        end
      end
      vln_pkg::ST_SQRT: begin
        srem_q <= sq_ge ? sq_sub[vln_pkg::SREM_W-1:0] : srem2[vln_pkg::SREM_W-1:0];
        quo_q  <= {quo_q[vln_pkg::QUO_W-3:0], 2'b00};
        root_q <= root_d;
        step_q <= step_q - vln_pkg::STEP_W'(1);
        if (rounded[vln_pkg::ROOT_W]) begin
          res_q <= vln_pkg::MAG_SAT;
        end else begin
          res_q <= rounded[vln_pkg::MAG_W:1];
        end
      end
      default: begin
        step_q <= step_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= signed_res;
      out_last_q  <= is_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign normalized_value_o = out_value_q;
  assign last_element_o     = out_last_q;

endmodule

### src/vector_l2_normalizer.sv
// ----------------------------------------------------------------------------
// vector_l2_normalizer
// L2 normalisation of a vector: Q4.12 elements in, Q1.15 elements out.
// ----------------------------------------------------------------------------
// Input channel: one element per request on in_valid_i / in_stall_o. After
// vector_length elements (0 acts as 1, above 64 as 64) the vector is closed
// and handed to the back end; a write on cfg_we_i drops any partial vector.
// While in_stall_o is low the front takes one element per cycle into one of
// two store banks, so a second vector can be loaded while the first is being
// emitted; in_stall_o rises only while both banks hold vectors being emitted.
// Output channel: every element of a closed vector, in order, scaled by the
// reciprocal of the vector norm and saturated to +/-32767, with
// last_element_o on the final one. An all-zero vector gives zeros.
// Each result goes through store read, square, a 32-step restoring divide
// and a 16-step integer square root, one element at a time; the divide and
// the root are skipped when the sum is zero or the element holds all of it.
// The output register holds its request while out_stall_i is high; the back
// end computes the next element meanwhile and waits to load it.
// Reset clears the length to 64, empties the queue and drops all requests.
// ----------------------------------------------------------------------------
module vector_l2_normalizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vln_pkg::LEN_W-1:0]          vector_length_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [vln_pkg::DATA_W-1:0]  element_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [vln_pkg::DATA_W-1:0]  normalized_value_o,
  output logic                               last_element_o
);

  logic                       push;
  vln_pkg::desc_t             push_desc;
  logic                       pop;
  logic                       head_valid;
  vln_pkg::desc_t             head;
  logic [vln_pkg::QCNT_W-1:0] q_count;
  vln_pkg::mem_wr_t           mem_wr;

  vln_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .vector_length_i (vector_length_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .element_value_i (element_value_i),
    .q_count_i       (q_count),
    .push_o          (push),
    .push_desc_o     (push_desc),
    .mem_wr_o        (mem_wr)
  );

  vln_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (q_count)
  );

  vln_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .mem_wr_i           (mem_wr),
    .head_valid_i       (head_valid),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .normalized_value_o (normalized_value_o),
    .last_element_o     (last_element_o)
  );

endmodule

### src/vln_checker.sv
// ----------------------------------------------------------------------------
// vln_checker
// Port-level checks of the normaliser: output hold, range and vector framing.
// ----------------------------------------------------------------------------
module vln_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vln_pkg::LEN_W-1:0]          vector_length_i,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic signed [vln_pkg::DATA_W-1:0]  normalized_value_o,
  input  logic                               last_element_o
);

  logic [vln_pkg::LEN_W-1:0] len_q;
  logic [vln_pkg::LEN_W-1:0] ocnt_q;
  logic                      out_take;
  logic [vln_pkg::LEN_W-1:0] ocnt_next;

  assign out_take  = out_valid_o && !out_stall_i;
  assign ocnt_next = ocnt_q + vln_pkg::LEN_W'(1);

  // shadow of the effective length and of the results sent in this vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= vln_pkg::LEN_RESET;
      ocnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        len_q <= vln_pkg::eff_length(vector_length_i);
      end
      if (out_take) begin
        ocnt_q <= last_element_o ? '0 : ocnt_next;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(normalized_value_o) && $stable(last_element_o))
    else $error("output request changed while stalled");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normalized_value_o != 16'sh8000)
    else $error("result outside saturation range");

  a_last_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && last_element_o |-> ocnt_next == len_q)
    else $error("last element flagged at wrong position");

  a_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !last_element_o |-> ocnt_next < len_q)
    else $error("vector ran past its length without last flag");

endmodule

bind vector_l2_normalizer vln_checker u_vln_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .cfg_we_i           (cfg_we_i),
  .vector_length_i    (vector_length_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .normalized_value_o (normalized_value_o),
  .last_element_o     (last_element_o)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives vectors of Q4.12 elements into the L2 normaliser under several
// length settings and idle patterns, predicts each Q1.15 output from the
// exact integer norm and checks every result and its last flag in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int BACK_LATENCY = 60;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_CFG [PHASES]  = '{2, 127, 7, 0, 16, 5, 100, 3};
  localparam int PHASE_VECS [PHASES] = '{12, 1, 4, 20, 4, 10, 1, 10};

  typedef enum int {VEC_RANDOM, VEC_ZERO, VEC_SPIKE, VEC_SMALL, VEC_EXTREME} vec_shape_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_e;

  class l2_result_board;
    typedef struct packed {
      logic signed [vln_pkg::DATA_W-1:0] value;
      logic                              last;
    } norm_result_t;

    logic signed [vln_pkg::DATA_W-1:0] held [vln_pkg::MAX_LENGTH];
    bit [vln_pkg::LEN_W-1:0]           length_reg;
    int unsigned                       filled;
    bit [vln_pkg::SUM_W-1:0]           energy;
    norm_result_t                      pending_results [$];
    int unsigned                       errors;
    int unsigned                       checked;
    int unsigned                       vectors;

    function new();
      length_reg = vln_pkg::LEN_W'(vln_pkg::MAX_LENGTH);
    endfunction

    function void set_length(bit [vln_pkg::LEN_W-1:0] v);
      length_reg = v;
      filled     = 0;
      energy     = '0;
    endfunction

    function int unsigned active_length();
      if (length_reg == 0) return 1;
      if (length_reg > vln_pkg::MAX_LENGTH) return vln_pkg::MAX_LENGTH;
      return length_reg;
    endfunction

    // round(|x| * 2^15 / sqrt(s)), ties up, found bit by bit from the top
    static function logic signed [vln_pkg::DATA_W-1:0] q15_scale(
        logic signed [vln_pkg::DATA_W-1:0] x,
        bit [vln_pkg::SUM_W-1:0]           s);
      bit [16:0]  mag;
      bit [16:0]  r;
      bit [16:0]  cand;
      bit [127:0] bound;
      bit [127:0] odd;
      logic [15:0] q;
      mag = x[15] ? (~{1'b1, x} + 17'd1) : {1'b0, x};
      if (s == 0 || mag == 0) return '0;
      bound = (128'(mag) * 128'(mag)) << 32;
      r = '0;
      for (int b = 16; b >= 0; b--) begin
        cand = r | (17'd1 << b);
        odd  = 128'(cand) * 2 - 1;
        if (odd * odd * 128'(s) <= bound) r = cand;
      end
      if (r > 17'd32767) r = 17'd32767;
      q = r[15:0];
      return x[15] ? -q : q;
    endfunction

    function void note_element(logic signed [vln_pkg::DATA_W-1:0] x);
      int sq;
      int unsigned len;
      norm_result_t res;
      len = active_length();
      sq = x * x;
      held[filled] = x;
      energy = energy + vln_pkg::SUM_W'(sq);
      filled++;
      if (filled >= len) begin
        for (int k = 0; k < len; k++) begin
          res.value = q15_scale(held[k], energy);
          res.last  = (k == len - 1);
          pending_results.insert(pending_results.size(), res);
        end
        vectors++;
        filled = 0;
        energy = '0;
      end
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("error: %s", what);
    endfunction

    function void check_result(logic signed [vln_pkg::DATA_W-1:0] value, logic last);
      norm_result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result value %0d last %0b", value, last));
        return;
      end
      want = pending_results.pop_front();
      if (want.value !== value || want.last !== last) begin
        report($sformatf("result %0d: expected value %0d last %0b, got value %0d last %0b",
                         checked, want.value, want.last, value, last));
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [vln_pkg::LEN_W-1:0]         vector_length_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic signed [vln_pkg::DATA_W-1:0] element_value_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [vln_pkg::DATA_W-1:0] normalized_value_o;
  logic                              last_element_o;

  l2_result_board board = new();

  int          cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned elements_sent = 0;
  int unsigned settings_seen = 0;

  vector_l2_normalizer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .vector_length_i    (vector_length_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .element_value_i    (element_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .normalized_value_o (normalized_value_o),
    .last_element_o     (last_element_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // cycle count and watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(normalized_value_o, last_element_o);
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 48;
        stall_pct     = 0;
      end
      IDLE_STALL: begin
        send_idle_pct = 0;
        stall_pct     = 48;
      end
      default: begin
        send_idle_pct = 33;
        stall_pct     = 33;
      end
    endcase
  endtask

  task automatic send_element(logic signed [vln_pkg::DATA_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_element(v);
    elements_sent++;
  endtask

  // only once the block has drained; any partial vector in flight is dropped by the write
  task automatic write_length(bit [vln_pkg::LEN_W-1:0] v);
    in_valid_i <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (BACK_LATENCY) @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    vector_length_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_length(v);
    settings_seen++;
  endtask

  function automatic logic signed [vln_pkg::DATA_W-1:0] random_element(
      vec_shape_e shape, int pos, int hot);
    case (shape)
      VEC_ZERO:  return '0;
      VEC_SPIKE: return (pos == hot) ? vln_pkg::DATA_W'($urandom) : '0;
      VEC_SMALL: return vln_pkg::DATA_W'(int'($urandom_range(0, 8)) - 4);
      VEC_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0001;
          3:       return 16'shffff;
          default: return 16'sh0000;
        endcase
      end
      default:   return vln_pkg::DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_vector(int len, int count);
    vec_shape_e shape;
    int pick;
    int hot;
    pick = $urandom_range(0, 9);
    if (pick < 5) shape = VEC_RANDOM;
    else if (pick == 5) shape = VEC_ZERO;
    else if (pick == 6) shape = VEC_SPIKE;
    else if (pick == 7) shape = VEC_SMALL;
    else shape = VEC_EXTREME;
    hot = $urandom_range(0, len - 1);
    for (int i = 0; i < count; i++) send_element(random_element(shape, i, hot));
  endtask

  initial begin
    int len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(IDLE_NONE);
    // partial vector at the reset length is dropped by the length write
    send_element(16'sh7fff);
    send_element(16'sh8000);
    send_element(16'sh0001);
    write_length(7'd0);
    send_element(16'sh0000);
    send_element(16'sh7fff);
    send_element(16'sh8000);
    send_element(16'sh0001);
    send_element(16'shffff);
    send_element(16'sh1234);
    write_length(7'd3);
    send_element(16'sh7fff);
    send_element(16'sh7fff);
    send_element(16'sh8000);
    send_element(16'sh0000);
    send_element(16'sh0000);
    send_element(16'sh0000);
    send_element(16'sh0000);
    send_element(-16'sd5);
    send_element(16'sh0000);
    write_length(7'd4);
    send_element(16'sd3);
    send_element(16'sd4);
    write_length(7'd2);
    send_element(16'sd3);
    send_element(16'sd4);
    send_element(16'sh8000);
    send_element(16'sh8000);

    for (int p = 0; p < PHASES; p++) begin
      write_length(vln_pkg::LEN_W'(PHASE_CFG[p]));
      set_idling(idle_mode_e'(p % 4));
      len = board.active_length();
      for (int v = 0; v < PHASE_VECS[p]; v++) send_vector(len, len);
      // now and then leave a broken vector for the next length write to drop
      if (len > 1 && $urandom_range(0, 1) == 1) send_vector(len, $urandom_range(1, len - 1));
    end

    in_valid_i <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (BACK_LATENCY) @(posedge clk_i);
    if (board.pending_results.size() != 0) begin
      board.report($sformatf("%0d results never arrived", board.pending_results.size()));
    end

    $display("sent %0d elements under %0d length settings and four idle patterns",
             elements_sent, settings_seen);
    $display("%0d vectors closed, %0d results checked, %0d failures",
             board.vectors, board.checked, board.errors);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
